@@ rtl/vrm_pkg.sv @@
// shared types and constants for the vertex reorder block
package vrm_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 65536;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;
  localparam int EDGE_W       = $clog2(MAX_EDGES) + 1;
  localparam int SUM_W        = 32;
  localparam int FREQ_W       = 18;
  localparam int PROD_W       = SUM_W + FREQ_W;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNRANKED = 2'd3
  } status_e_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK,
    S_E_RD_S, S_E_WR_S, S_E_RD_D, S_E_WR_D,
    S_F_RD_V, S_F_LD_V, S_F_RD_U, S_F_MUL, S_F_CMP, S_F_WR,
    S_Q_RD, S_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic latch_status;
    logic rd_src;
    logic wr_src;
    logic rd_dst;
    logic wr_dst;
    logic fin_start;
    logic rd_v;
    logic ld_v;
    logic rd_u;
    logic mul;
    logic cmp;
    logic wr_rank;
    logic q_rd;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic      clr_last;
    cmd_e_t    cmd;
    status_e_t check;
    logic      u_last;
    logic      v_last;
    logic      out_free;
  } stat_t;

endpackage

@@ rtl/vrm_ctrl.sv @@
// controller state machine for the vertex reorder block
module vrm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  vrm_pkg::stat_t st,
  output vrm_pkg::ctrl_t ctl
);
  import vrm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.latch_status = 1'b1;
        priority if (st.cmd == CMD_FINISH) begin
          ctl.fin_start = 1'b1;
          state_next    = S_F_RD_V;
        end else if (st.cmd == CMD_ADD && st.check == ST_OK) begin
          state_next = S_E_RD_S;
        end else if (st.cmd == CMD_READ && st.check == ST_OK) begin
          state_next = S_Q_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_E_RD_S: begin
        ctl.rd_src = 1'b1;
        state_next = S_E_WR_S;
      end
      S_E_WR_S: begin
        ctl.wr_src = 1'b1;
        state_next = S_E_RD_D;
      end
      S_E_RD_D: begin
        ctl.rd_dst = 1'b1;
        state_next = S_E_WR_D;
      end
      S_E_WR_D: begin
        ctl.wr_dst = 1'b1;
        state_next = S_RESULT;
      end
      S_F_RD_V: begin
        ctl.rd_v   = 1'b1;
        state_next = S_F_LD_V;
      end
      S_F_LD_V: begin
        ctl.ld_v   = 1'b1;
        state_next = S_F_RD_U;
      end
      S_F_RD_U: begin
        ctl.rd_u   = 1'b1;
        state_next = S_F_MUL;
      end
      S_F_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_F_CMP;
      end
      S_F_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = st.u_last ? S_F_WR : S_F_RD_U;
      end
      S_F_WR: begin
        ctl.wr_rank = 1'b1;
        state_next  = st.v_last ? S_RESULT : S_F_RD_V;
      end
      S_Q_RD: begin
        ctl.q_rd   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

@@ rtl/vrm_dp.sv @@
// datapath: vertex memories, rank memory, comparator and result register
module vrm_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  vrm_pkg::ctrl_t              ctl,
  output vrm_pkg::stat_t              st,
  input  logic                        cfg_write,
  input  logic [10:0]                 cfg_data,
  input  logic [1:0]                  command,
  input  logic [vrm_pkg::VTX_W-1:0]   src_vertex,
  input  logic [vrm_pkg::VTX_W-1:0]   dst_vertex,
  input  logic [vrm_pkg::VTX_W-1:0]   query_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vrm_pkg::VTX_W-1:0]   new_position,
  output logic [1:0]                  status
);
  import vrm_pkg::*;

  logic [SUM_W-1:0]  mem_sum  [MAX_VERTICES];
  logic [FREQ_W-1:0] mem_freq [MAX_VERTICES];
  logic [VTX_W-1:0]  mem_rank [MAX_VERTICES];

  logic [10:0]       vertex_count;
  logic              ranked;
  logic [EDGE_W-1:0] edge_counter;
  logic [VTX_W-1:0]  clr_cnt;

  cmd_e_t            cmd;
  logic [VTX_W-1:0]  src, dst, qv;
  status_e_t         res_status;
  status_e_t         check;

  logic [SUM_W-1:0]  rd_sum;
  logic [FREQ_W-1:0] rd_freq;
  logic [VTX_W-1:0]  rank_rd;
  logic [SUM_W-1:0]  v_sum;
  logic [FREQ_W-1:0] v_freq;
  logic [PROD_W-1:0] prod_l, prod_r;
  logic [VTX_W-1:0]  u, v, rank_cnt;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_last;
  logic [VTX_W-1:0]  rd_addr, wr_addr;
  logic              wr_en;
  logic [SUM_W-1:0]  wr_sum;
  logic [FREQ_W-1:0] wr_freq;
  logic              u_ahead;

  // effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    priority if (vertex_count == '0) begin
      n = CNT_W'(1);
    end else if (vertex_count > 11'(MAX_VERTICES)) begin
      n = CNT_W'(MAX_VERTICES);
    end else begin
      n = CNT_W'(vertex_count);
    end
  end
  assign n_last = n - CNT_W'(1);

  always_comb begin
    priority if (cmd == CMD_ADD) begin
      priority if ({1'b0, src} >= n || {1'b0, dst} >= n) check = ST_RANGE;
      else if (edge_counter >= EDGE_W'(MAX_EDGES))     check = ST_FULL;
      else                                              check = ST_OK;
    end else if (cmd == CMD_READ) begin
      priority if ({1'b0, qv} >= n) check = ST_RANGE;
      else if (!ranked)            check = ST_UNRANKED;
      else                         check = ST_OK;
    end else begin
      check = ST_OK;
    end
  end

  assign st.check    = check;
  assign st.cmd      = cmd;
  assign st.clr_last = (clr_cnt == '1);
  assign st.u_last   = ({1'b0, u} == n_last);
  assign st.v_last   = ({1'b0, v} == n_last);
  assign st.out_free = !out_valid || !out_stall;

  // memory port selection
  always_comb begin
    priority if (ctl.rd_src)    rd_addr = src;
    else if (ctl.rd_dst)        rd_addr = dst;
    else if (ctl.rd_v)          rd_addr = v;
    else if (ctl.rd_u)          rd_addr = u;
    else                        rd_addr = clr_cnt;
  end

  always_comb begin
    wr_en = ctl.clear_step || ctl.wr_src || ctl.wr_dst;
    priority if (ctl.clear_step) begin
      wr_addr = clr_cnt;
      wr_sum  = '0;
      wr_freq = FREQ_W'(1);
    end else begin
      wr_addr = ctl.wr_src ? src : dst;
      wr_sum  = rd_sum + SUM_W'(edge_counter);
      wr_freq = rd_freq + FREQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_sum[wr_addr]  <= wr_sum;
      mem_freq[wr_addr] <= wr_freq;
    end
    rd_sum  <= mem_sum[rd_addr];
    rd_freq <= mem_freq[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_rank) begin
      mem_rank[v] <= rank_cnt;
    end
    if (ctl.q_rd) begin
      rank_rd <= mem_rank[qv];
    end
  end

  // u ranks ahead of v: lower mean, ties to the lower index
  assign u_ahead = (u != v) && ((prod_l < prod_r) || (prod_l == prod_r && u < v));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd <= cmd_e_t'(command);
      src <= src_vertex;
      dst <= dst_vertex;
      qv  <= query_vertex;
    end
    if (ctl.latch_status) begin
      res_status <= check;
    end
    if (ctl.ld_v) begin
      v_sum    <= rd_sum;
      v_freq   <= rd_freq;
      u        <= '0;
      rank_cnt <= '0;
    end
    if (ctl.mul) begin
      prod_l <= PROD_W'(rd_sum) * PROD_W'(v_freq);
      prod_r <= PROD_W'(v_sum) * PROD_W'(rd_freq);
    end
    if (ctl.cmp) begin
      u        <= u + VTX_W'(1);
      rank_cnt <= rank_cnt + VTX_W'(u_ahead);
    end
    if (ctl.fin_start) begin
      v <= '0;
    end else if (ctl.wr_rank) begin
      v <= v + VTX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 11'(MAX_VERTICES);
      ranked       <= 1'b0;
      edge_counter <= '0;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (ctl.clear_step) clr_cnt <= clr_cnt + VTX_W'(1);
      if (ctl.wr_dst) edge_counter <= edge_counter + EDGE_W'(1);
      if (cfg_write) begin
        vertex_count <= cfg_data;
        ranked       <= 1'b0;
      end else if (ctl.wr_dst) begin
        ranked <= 1'b0;
      end else if (ctl.wr_rank && st.v_last) begin
        ranked <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status       <= res_status;
      new_position <= (cmd == CMD_READ && res_status == ST_OK) ? rank_rd : '0;
    end
  end

endmodule

@@ rtl/vertex_reorder_by_mean_edge_index_core.sv @@
// top level of the vertex reorder block
// Edges, finish and read commands come in one at a time; each gives one result
// (new_position, status) through an output register. After reset the vertex
// memories are cleared, every address, before the first command is taken.
// A finish compares every vertex against every vertex, itself included,
// through the single read port of the vertex memories; each pair is read,
// multiplied and compared in turn. Writes to vertex_count must come only in
// idle time; the block itself does not enforce this. A write drops any
// earlier ranking.
module vertex_reorder_by_mean_edge_index_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [10:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                command,
  input  logic [vrm_pkg::VTX_W-1:0] src_vertex,
  input  logic [vrm_pkg::VTX_W-1:0] dst_vertex,
  input  logic [vrm_pkg::VTX_W-1:0] query_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [vrm_pkg::VTX_W-1:0] new_position,
  output logic [1:0]                status
);
  import vrm_pkg::*;

  ctrl_t ctl;
  stat_t st;

  vrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  vrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .command      (command),
    .src_vertex   (src_vertex),
    .dst_vertex   (dst_vertex),
    .query_vertex (query_vertex),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_position (new_position),
    .status       (status)
  );

`ifndef SYNTH
  // a result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // after a transfer in, the block is busy
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer accepted while busy");

  // a command with an error status reports position zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (new_position == '0))
    else $error("nonzero position with error status");
`endif

endmodule
